@@ sv/arbm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arbm_pkg
// Shared types and constants for the auto-ranging level bar meter: widths,
// reset values, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package arbm_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int CAL_W    = 8;
    localparam int PCT_W    = 7;
    localparam int BAR_W    = 4;
    // (sample - min) * 100 fits in 19 bits
    localparam int NUM_W    = 19;
    // quotient is at most 100, so seven quotient bits
    localparam int STEP_W   = 3;

    // reset values of the tracked range and the calibration length
    localparam logic [SAMPLE_W-1:0] MIN_RESET = 12'd4095;
    localparam logic [SAMPLE_W-1:0] MAX_RESET = 12'd3240;
    localparam logic [CAL_W-1:0]    CAL_RESET = 8'd10;

    // scale and bar thresholds
    localparam logic [PCT_W-1:0] FULL_SCALE = 7'd100;
    localparam logic [PCT_W-1:0] LED0_LEVEL = 7'd20;
    localparam logic [PCT_W-1:0] LED1_LEVEL = 7'd40;
    localparam logic [PCT_W-1:0] LED2_LEVEL = 7'd60;
    localparam logic [PCT_W-1:0] LED3_LEVEL = 7'd80;

    // first quotient bit tried by the divider
    localparam logic [STEP_W-1:0] STEP_FIRST = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd0;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } arbm_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;     // take a sample request, update range and count
        logic prep;       // form numerator and divisor
        logic div_step;   // one restoring division step
        logic load_out;   // move the result into the output register
    } arbm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic calibrating;  // count still below calibration length
        logic div_last;     // current division step is the final one
        logic out_free;     // output register can take a result now
    } arbm_status_t;

endpackage

@@ sv/arbm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arbm_ctrl
// Sequencer: accepts a sample request, skips result work while calibrating,
// then steps the datapath through preparation, division and output load.
// ----------------------------------------------------------------------------
module arbm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  arbm_pkg::arbm_status_t status,
    output arbm_pkg::arbm_cmd_t    cmd
);
    import arbm_pkg::*;

    arbm_state_t state_reg;
    arbm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !status.calibrating)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // a calibration sample leaves the sequencer idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && status.calibrating) |=> (state_reg == ST_IDLE))
        else $error("calibration sample started result work");

    // a result load always returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after output load");

    // only one command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.prep, cmd.div_step, cmd.load_out}))
        else $error("more than one datapath command issued");

endmodule

@@ sv/arbm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arbm_dp
// Datapath: tracked range, calibration count, numerator and divisor set-up,
// a seven-step restoring divider and the output register with bar decode.
// ----------------------------------------------------------------------------
module arbm_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  arbm_pkg::arbm_cmd_t             cmd,
    output arbm_pkg::arbm_status_t          status,
    input  logic [arbm_pkg::SAMPLE_W-1:0]   sample,
    input  logic                           cfg_valid,
    input  logic [arbm_pkg::CAL_W-1:0]      cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [arbm_pkg::PCT_W-1:0]      percent,
    output logic [arbm_pkg::BAR_W-1:0]      bar_leds,
    output logic [arbm_pkg::SAMPLE_W-1:0]   range_low,
    output logic [arbm_pkg::SAMPLE_W-1:0]   range_high
);
    import arbm_pkg::*;

    logic [SAMPLE_W-1:0] min_reg;
    logic [SAMPLE_W-1:0] max_reg;
    logic [SAMPLE_W-1:0] min_next;
    logic [SAMPLE_W-1:0] max_next;
    logic [CAL_W-1:0]    cal_len_reg;
    logic [CAL_W-1:0]    count_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [SAMPLE_W-1:0] div_reg;
    logic [PCT_W-1:0]    quot_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic [BAR_W-1:0]    bar_reg;
    logic [SAMPLE_W-1:0] low_reg;
    logic [SAMPLE_W-1:0] high_reg;

    logic                range_pos;
    logic [SAMPLE_W-1:0] diff;
    logic [NUM_W-1:0]    numerator;
    logic [NUM_W-1:0]    div_shifted;
    logic                fits;
    logic [BAR_W-1:0]    bar_next;

    // range update with the incoming sample
    assign min_next = (sample < min_reg) ? sample : min_reg;
    assign max_next = (sample > max_reg) ? sample : max_reg;

    // status back to the controller
    assign status.calibrating = (count_reg < cal_len_reg);
    assign status.div_last    = (step_reg == STEP_LAST);
    assign status.out_free    = !out_valid_reg || out_ready;

    // tracked range, calibration length and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg     <= MIN_RESET;
            max_reg     <= MAX_RESET;
            cal_len_reg <= CAL_RESET;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cal_len_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                min_reg <= min_next;
                max_reg <= max_next;
                if (status.calibrating)
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
        end
    end

    // numerator and divisor set-up
    assign range_pos = (max_reg > min_reg);
    assign diff      = sample_reg - min_reg;
    assign numerator = NUM_W'(diff) * NUM_W'(FULL_SCALE);

    // one restoring step per cycle
    assign div_shifted = NUM_W'(div_reg) << step_reg;
    assign fits        = (rem_reg >= div_shifted);

    // sample hold and divider
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample;
        end
        if (cmd.prep)
        begin
            // an empty or inverted range divides zero by one
            rem_reg  <= range_pos ? numerator : '0;
            div_reg  <= range_pos ? (max_reg - min_reg) : SAMPLE_W'(1);
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (fits)
            begin
                rem_reg            <= rem_reg - div_shifted;
                quot_reg[step_reg] <= 1'b1;
            end
        end
    end

    // division step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FIRST;
        end
        else if (cmd.prep)
        begin
            step_reg <= STEP_FIRST;
        end
        else if (cmd.div_step && !status.div_last)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    // thermometer bar
    always_comb
    begin
        bar_next    = '0;
        bar_next[0] = (quot_reg >= LED0_LEVEL);
        bar_next[1] = (quot_reg >= LED1_LEVEL);
        bar_next[2] = (quot_reg >= LED2_LEVEL);
        bar_next[3] = (quot_reg >= LED3_LEVEL);
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pct_reg  <= quot_reg;
            bar_reg  <= bar_next;
            low_reg  <= min_reg;
            high_reg <= max_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign percent    = pct_reg;
    assign bar_leds   = bar_reg;
    assign range_low  = low_reg;
    assign range_high = high_reg;

    // percent never passes full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (quot_reg <= FULL_SCALE))
        else $error("quotient above full scale");

    // the minimum never rises
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (min_reg <= $past(min_reg)))
        else $error("tracked minimum increased");

    // the count only moves on an accepted sample
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.accept |=> $stable(count_reg))
        else $error("calibration count changed without a sample");

endmodule

@@ sv/auto_ranging_level_bar_meter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// auto_ranging_level_bar_meter_top
// Auto-ranging level meter: running min/max tracking, percent position of
// each sample in that range and a four-segment thermometer bar.
// ----------------------------------------------------------------------------
// Each sample request updates the tracked minimum and maximum at once. While
// the calibration count is below the calibration length a request only advances
// the count, produces no result and the block is ready again on the next
// cycle. Any other request passes in order through acceptance, forming
// (sample - min) * 100 and the divisor, seven steps of the restoring divider
// that yields one quotient bit per cycle, and finally the load of the
// output register. The output register holds a
// finished result until taken; if it is still occupied the next result waits
// in the sequencer and no new request is taken. The register write port is
// always ready and writing it clears neither the count nor the range.
// ----------------------------------------------------------------------------
module auto_ranging_level_bar_meter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [arbm_pkg::CAL_W-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [arbm_pkg::SAMPLE_W-1:0]   sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [arbm_pkg::PCT_W-1:0]      percent,
    output logic [arbm_pkg::BAR_W-1:0]      bar_leds,
    output logic [arbm_pkg::SAMPLE_W-1:0]   range_low,
    output logic [arbm_pkg::SAMPLE_W-1:0]   range_high
);
    import arbm_pkg::*;

    arbm_cmd_t    cmd;
    arbm_status_t status;

    // register port always takes a write
    assign cfg_ready = 1'b1;

    // sequencer
    arbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    arbm_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample     (sample),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .percent    (percent),
        .bar_leds   (bar_leds),
        .range_low  (range_low),
        .range_high (range_high)
    );

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the auto-ranging level bar meter. A short table of
// directed rows is followed by randomised sample requests over several
// calibration lengths. Every result is compared with an in-bench predictor of
// the tracked range, percent position and thermometer bar, or a typed want.
// ----------------------------------------------------------------------------
module tb;
    import arbm_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DIR_ROWS     = 25;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        logic [PCT_W-1:0]    pct;
        logic [BAR_W-1:0]    bar;
        logic [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0] hi;
    } level_t;

    typedef struct packed {
        row_kind_t           kind;
        logic [SAMPLE_W-1:0] value;
        logic                typed;
        level_t              want;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CAL_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample;
    logic                out_valid;
    logic                out_ready;
    logic [PCT_W-1:0]    percent;
    logic [BAR_W-1:0]    bar_leds;
    logic [SAMPLE_W-1:0] range_low;
    logic [SAMPLE_W-1:0] range_high;

    // predictor state
    logic [SAMPLE_W-1:0] lvl_min;
    logic [SAMPLE_W-1:0] lvl_max;
    logic [CAL_W-1:0]    cal_count;
    logic [CAL_W-1:0]    cal_len;
    level_t              pending_levels[$];

    int errors    = 0;
    int cycles    = 0;
    bit hold_long = 1'b0;
    bit calm      = 1'b0;

    // directed rows: typed expectations only where obvious
    row_t dir_rows [0:DIR_ROWS-1] = '{
        '{ROW_CFG,    12'd0,    1'b0, '0},
        '{ROW_SAMPLE, 12'd3240, 1'b1, '{7'd0,   4'd0,  12'd3240, 12'd3240}},
        '{ROW_SAMPLE, 12'd3241, 1'b1, '{7'd100, 4'd15, 12'd3240, 12'd3241}},
        '{ROW_SAMPLE, 12'd3240, 1'b1, '{7'd0,   4'd0,  12'd3240, 12'd3241}},
        '{ROW_SAMPLE, 12'd3230, 1'b0, '0},
        '{ROW_SAMPLE, 12'd3235, 1'b0, '0},
        '{ROW_CFG,    12'd3,    1'b0, '0},
        '{ROW_SAMPLE, 12'd3300, 1'b0, '0},
        '{ROW_SAMPLE, 12'd3100, 1'b0, '0},
        '{ROW_SAMPLE, 12'd3200, 1'b0, '0},
        '{ROW_SAMPLE, 12'd3250, 1'b0, '0},
        '{ROW_CFG,    12'd1,    1'b0, '0},
        '{ROW_SAMPLE, 12'd3150, 1'b0, '0},
        '{ROW_CFG,    12'd5,    1'b0, '0},
        '{ROW_SAMPLE, 12'd3000, 1'b0, '0},
        '{ROW_SAMPLE, 12'd3400, 1'b0, '0},
        '{ROW_SAMPLE, 12'd3200, 1'b0, '0},
        '{ROW_CFG,    12'd0,    1'b0, '0},
        '{ROW_SAMPLE, 12'd0,    1'b1, '{7'd0,   4'd0,  12'd0,    12'd3400}},
        '{ROW_SAMPLE, 12'd4095, 1'b1, '{7'd100, 4'd15, 12'd0,    12'd4095}},
        '{ROW_SAMPLE, 12'd819,  1'b0, '0},
        '{ROW_SAMPLE, 12'd1638, 1'b0, '0},
        '{ROW_SAMPLE, 12'd2457, 1'b0, '0},
        '{ROW_SAMPLE, 12'd3276, 1'b0, '0},
        '{ROW_SAMPLE, 12'd818,  1'b0, '0}
    };

    auto_ranging_level_bar_meter_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .percent    (percent),
        .bar_leds   (bar_leds),
        .range_low  (range_low),
        .range_high (range_high)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #HALF_PERIOD clk = ~clk;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    // range update, calibration count and expected level for one sample
    function automatic void predict_level(input logic [SAMPLE_W-1:0] s, input bit typed,
                                          input level_t want);
        level_t lvl;
        int     span;
        int     pos;
        if (s < lvl_min)
            lvl_min = s;
        if (s > lvl_max)
            lvl_max = s;
        if (cal_count < cal_len)
        begin
            cal_count = cal_count + 1'b1;
            return;
        end
        pos = 0;
        if (lvl_max > lvl_min)
        begin
            span = int'(lvl_max) - int'(lvl_min);
            pos  = ((int'(s) - int'(lvl_min)) * 100) / span;
        end
        lvl.pct = pos[PCT_W-1:0];
        // thermometer at 20/40/60/80 percent
        lvl.bar = {pos >= 80, pos >= 60, pos >= 40, pos >= 20};
        lvl.lo  = lvl_min;
        lvl.hi  = lvl_max;
        pending_levels.push_back(typed ? want : lvl);
    endfunction

    // mostly uniform, with full-scale ends and bar threshold neighbours
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int roll;
        int step_pct;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return ($urandom_range(0, 1) != 0) ? 12'hFFF : 12'h000;
        if (roll <= 2)
        begin
            step_pct = 20 * $urandom_range(1, 4);
            return SAMPLE_W'((step_pct * 4095 + 99) / 100 + int'($urandom_range(0, 2)) - 1);
        end
        return SAMPLE_W'($urandom);
    endfunction

    // one sample request, held until taken
    task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                                input level_t want);
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= s;
        do
            @(posedge clk);
        while (!in_ready);
        predict_level(s, typed, want);
    endtask

    task automatic sender_gap(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // stop offering and wait for every pending level plus settling time
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cal_len(input logic [CAL_W-1:0] v);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cal_len = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_long)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_long = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                gap = $urandom_range(1, 6);
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        level_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_levels.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending (percent %0d)", percent));
            end
            else
            begin
                want = pending_levels.pop_front();
                if (percent !== want.pct)
                    report_mismatch($sformatf("percent %0d, expected %0d", percent, want.pct));
                if (bar_leds !== want.bar)
                    report_mismatch($sformatf("bar_leds %0h, expected %0h", bar_leds, want.bar));
                if (range_low !== want.lo)
                    report_mismatch($sformatf("range_low %0d, expected %0d", range_low, want.lo));
                if (range_high !== want.hi)
                    report_mismatch($sformatf("range_high %0d, expected %0d", range_high,
                                              want.hi));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int               r;
        int               p;
        int               i;
        logic [CAL_W-1:0] phase_len;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        lvl_min   = 12'd4095;
        lvl_max   = 12'd3240;
        cal_count = 8'd0;
        cal_len   = 8'd10;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows
        for (r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_rows[r].kind == ROW_CFG)
                write_cal_len(dir_rows[r].value[CAL_W-1:0]);
            else
                offer_sample(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].want);
        end

        // random phases over several calibration lengths
        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0, 6:    phase_len = 8'd0;
                1:       phase_len = 8'd40;
                2:       phase_len = 8'd255;
                4:       phase_len = 8'd1;
                5:       phase_len = 8'd128;
                default: phase_len = CAL_W'($urandom_range(1, 254));
            endcase
            write_cal_len(phase_len);
            calm = (p == PHASES - 1);
            // fill the block while results are held back
            if (p == 0)
                hold_long = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 3 && i == PHASE_ITEMS / 2)
                    drain_results();
                if (!calm && $urandom_range(0, 7) == 0)
                    sender_gap($urandom_range(1, 6));
                offer_sample(pick_sample(), 1'b0, '0);
            end
        end

        drain_results();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
sv/arbm_pkg.sv
sv/arbm_ctrl.sv
sv/arbm_dp.sv
sv/auto_ranging_level_bar_meter_top.sv
bench/tb.sv
